// ----- hw/rtl/crc_checked_frame_receiver_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet receiver
// Shared wrappers for clocked, reset-qualified checks.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CRC_CHECKED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define CCFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ccfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccfr_pkg
// Types and constants of the framed packet receiver with CRC-32 check.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // start, type, two length bytes, four CRC bytes, end
  localparam logic [16:0] FRAME_OVERHEAD = 17'd9;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_END_BYTE   = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME  = 2'd2;

  localparam logic [7:0]  START_BYTE_RST = 8'hAA;
  localparam logic [7:0]  END_BYTE_RST   = 8'hBB;
  localparam logic [15:0] MAX_FRAME_RST  = 16'd1033;

  // Verdict codes
  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_BAD_START = 3'd1;
  localparam logic [2:0] VERDICT_BAD_END   = 3'd2;
  localparam logic [2:0] VERDICT_BAD_CRC   = 3'd3;
  localparam logic [2:0] VERDICT_TOO_LONG  = 3'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CRC,
    PH_END
  } phase_t;

endpackage

// ----- hw/rtl/ccfr_crc_byte.sv -----
// ----------------------------------------------------------------------------
// ccfr_crc_byte
// One byte of MSB-first CRC-32 update (poly 0x04C11DB7), eight bit steps.
// ----------------------------------------------------------------------------
module ccfr_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {data_in, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ ccfr_pkg::CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- hw/rtl/crc_checked_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_unit
// Frame parser: start, type, 16-bit LE length, payload, 32-bit LE CRC, end.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports              | Word content
//  ---------+--------------------+---------------------------------------------
//  in       | in_t{valid,ready}  | tdata[7:0] rx_byte
//  out      | out_t{valid,ready} | tuser item_kind; tdata payload/type/len/verdict
//  cfg      | APB cfg_p*         | 0x0 start_byte, 0x4 end_byte, 0x8 max_frame_bytes
//
//  One word per cycle while the output is taken: a word is captured in the
//  input register, parsed and CRC-updated once the output register is free,
//  and its result (if any) lands in the output register, which drives out_tvalid.
//  The limit is the single-byte CRC update between the two registers.
//  Reset (rst_n low, synchronous) returns to idle and restores register defaults.
//  A stalled output holds the pipeline; in_tready drops only while both the
//  input and output registers are full and the output is not taken.
// ----------------------------------------------------------------------------
`include "crc_checked_frame_receiver_unit_macros.svh"

module crc_checked_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [7:0] payload_byte, [15:8] frame_type,
                                   // [31:16] frame_bytes, [34:32] verdict, rest 0
  output logic        out_tuser,   // [0] item_kind

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  start_byte_r;
  logic [7:0]  end_byte_r;
  logic [15:0] max_frame_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= ccfr_pkg::START_BYTE_RST;
      end_byte_r   <= ccfr_pkg::END_BYTE_RST;
      max_frame_r  <= ccfr_pkg::MAX_FRAME_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ccfr_pkg::REG_START_BYTE: start_byte_r <= cfg_pwdata[7:0];
        ccfr_pkg::REG_END_BYTE:   end_byte_r   <= cfg_pwdata[7:0];
        ccfr_pkg::REG_MAX_FRAME:  max_frame_r  <= cfg_pwdata[15:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ccfr_pkg::REG_START_BYTE: cfg_prdata = {24'd0, start_byte_r};
      ccfr_pkg::REG_END_BYTE:   cfg_prdata = {24'd0, end_byte_r};
      ccfr_pkg::REG_MAX_FRAME:  cfg_prdata = {16'd0, max_frame_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register and pipeline flow control
  // --------------------------------------------------------------------------
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_free;
  logic       advance;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_payload_r;
  logic [7:0]  out_type_r;
  logic [15:0] out_bytes_r;
  logic [2:0]  out_verdict_r;

  // Output register can take a new word when empty or being drained now.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  ccfr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] payload_len_r, payload_len_nxt;
  logic [31:0] running_crc_r, running_crc_nxt;
  logic [31:0] received_crc_r, received_crc_nxt;
  logic [7:0]  held_type_r, held_type_nxt;

  logic [31:0] crc_fed;
  logic [16:0] count_inc;
  logic [16:0] frame_total;
  logic        is_start;

  ccfr_crc_byte u_crc (
    .crc_in  (running_crc_r),
    .data_in (s1_byte_r),
    .crc_out (crc_fed)
  );

  assign count_inc   = {1'b0, byte_count_r} + 17'd1;
  assign frame_total = {1'b0, payload_len_r} + ccfr_pkg::FRAME_OVERHEAD;
  assign is_start    = (s1_byte_r == start_byte_r);

  // Next phase
  always_comb begin
    case (phase_r)
      ccfr_pkg::PH_TYPE:   phase_nxt = ccfr_pkg::PH_LEN_LO;
      ccfr_pkg::PH_LEN_LO: phase_nxt = ccfr_pkg::PH_LEN_HI;
      ccfr_pkg::PH_LEN_HI: begin
        phase_nxt = ({s1_byte_r, payload_len_r[7:0]} == 16'd0) ?
                    ccfr_pkg::PH_CRC : ccfr_pkg::PH_PAYLOAD;
      end
      ccfr_pkg::PH_PAYLOAD: begin
        phase_nxt = (count_inc >= {1'b0, payload_len_r}) ?
                    ccfr_pkg::PH_CRC : ccfr_pkg::PH_PAYLOAD;
      end
      ccfr_pkg::PH_CRC: begin
        phase_nxt = (count_inc >= 17'd4) ? ccfr_pkg::PH_END : ccfr_pkg::PH_CRC;
      end
      ccfr_pkg::PH_END: phase_nxt = ccfr_pkg::PH_IDLE;
      default:          phase_nxt = is_start ? ccfr_pkg::PH_TYPE : ccfr_pkg::PH_IDLE;
    endcase
  end

  // Datapath updates and result word
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_payload;
  logic [7:0]  res_type;
  logic [15:0] res_bytes;
  logic [2:0]  res_verdict;

  always_comb begin
    byte_count_nxt   = byte_count_r;
    payload_len_nxt  = payload_len_r;
    running_crc_nxt  = running_crc_r;
    received_crc_nxt = received_crc_r;
    held_type_nxt    = held_type_r;
    res_valid        = 1'b0;
    res_kind         = ccfr_pkg::KIND_VERDICT;
    res_payload      = 8'd0;
    res_type         = 8'd0;
    res_bytes        = 16'd0;
    res_verdict      = ccfr_pkg::VERDICT_OK;
    case (phase_r)
      ccfr_pkg::PH_TYPE: held_type_nxt = s1_byte_r;
      ccfr_pkg::PH_LEN_LO: payload_len_nxt = {8'd0, s1_byte_r};
      ccfr_pkg::PH_LEN_HI: begin
        payload_len_nxt = {s1_byte_r, payload_len_r[7:0]};
        byte_count_nxt  = 16'd0;
      end
      ccfr_pkg::PH_PAYLOAD: begin
        running_crc_nxt = crc_fed;
        byte_count_nxt  = (count_inc >= {1'b0, payload_len_r}) ? 16'd0 : count_inc[15:0];
        res_valid       = 1'b1;
        res_kind        = ccfr_pkg::KIND_PAYLOAD;
        res_payload     = s1_byte_r;
        res_type        = held_type_r;
      end
      ccfr_pkg::PH_CRC: begin
        // Little-endian: place the byte by its position in the CRC field.
        case (byte_count_r[1:0])
          2'd0:    received_crc_nxt = received_crc_r | {24'd0, s1_byte_r};
          2'd1:    received_crc_nxt = received_crc_r | {16'd0, s1_byte_r, 8'd0};
          2'd2:    received_crc_nxt = received_crc_r | {8'd0, s1_byte_r, 16'd0};
          default: received_crc_nxt = received_crc_r | {s1_byte_r, 24'd0};
        endcase
        byte_count_nxt = (count_inc >= 17'd4) ? 16'd0 : count_inc[15:0];
      end
      ccfr_pkg::PH_END: begin
        res_valid      = 1'b1;
        res_type       = held_type_r;
        byte_count_nxt = 16'd0;
        if (s1_byte_r != end_byte_r) begin
          res_verdict = ccfr_pkg::VERDICT_BAD_END;
        end else if (running_crc_r != received_crc_r) begin
          res_verdict = ccfr_pkg::VERDICT_BAD_CRC;
        end else if (frame_total > {1'b0, max_frame_r}) begin
          res_verdict = ccfr_pkg::VERDICT_TOO_LONG;
        end else begin
          res_bytes = frame_total[15:0];
        end
      end
      default: begin
        // Idle, or an unused phase code treated as idle.
        if (is_start) begin
          byte_count_nxt   = 16'd0;
          payload_len_nxt  = 16'd0;
          running_crc_nxt  = ccfr_pkg::CRC_INIT;
          received_crc_nxt = 32'd0;
          held_type_nxt    = 8'd0;
        end else begin
          res_valid   = 1'b1;
          res_verdict = ccfr_pkg::VERDICT_BAD_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ccfr_pkg::PH_IDLE;
      byte_count_r   <= 16'd0;
      payload_len_r  <= 16'd0;
      running_crc_r  <= ccfr_pkg::CRC_INIT;
      received_crc_r <= 32'd0;
      held_type_r    <= 8'd0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      payload_len_r  <= payload_len_nxt;
      running_crc_r  <= running_crc_nxt;
      received_crc_r <= received_crc_nxt;
      held_type_r    <= held_type_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind_r    <= res_kind;
      out_payload_r <= res_payload;
      out_type_r    <= res_type;
      out_bytes_r   <= res_bytes;
      out_verdict_r <= res_verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'd0, out_verdict_r, out_bytes_r, out_type_r, out_payload_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CCFR_ASSERT_IMPLIES(a_payload_word_clean, clk, rst_n,
    out_valid_r && (out_kind_r == ccfr_pkg::KIND_PAYLOAD),
    (out_verdict_r == ccfr_pkg::VERDICT_OK) && (out_bytes_r == 16'd0),
    "payload word carries verdict or length")
  `CCFR_ASSERT_IMPLIES(a_error_zero_len, clk, rst_n,
    out_valid_r && (out_kind_r == ccfr_pkg::KIND_VERDICT) &&
    (out_verdict_r != ccfr_pkg::VERDICT_OK),
    out_bytes_r == 16'd0,
    "error verdict carries nonzero frame length")
  `CCFR_ASSERT_IMPLIES(a_crc_count_range, clk, rst_n,
    phase_r == ccfr_pkg::PH_CRC,
    byte_count_r < 16'd4,
    "CRC byte position out of range")
  `CCFR_ASSERT_NEXT(a_end_to_idle, clk, rst_n,
    advance && (phase_r == ccfr_pkg::PH_END),
    (phase_r == ccfr_pkg::PH_IDLE) && out_valid_r,
    "end byte did not return to idle with a verdict")

endmodule

// ----- verif/crc_checked_frame_receiver_unit_tb.sv -----
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_unit_tb
// Self-checking bench for the framed packet receiver. Byte words are streamed
// in with random gaps. Every accepted byte runs through a parser model in the
// bench. Each result word is checked field by field against the oldest word
// the model has queued. Register settings are changed over the APB port
// between traffic phases and read back.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT     = 1_500_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;   // drain wait that outlasts the input and output registers
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned PHASE_BYTES     = 190;

  // Register index with no register behind it (writes are dropped)
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    FAULT_NONE,
    FAULT_END,
    FAULT_CRC,
    FAULT_BOTH
  } frame_fault_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [7:0]  ftype;
    logic [15:0] fbytes;
    logic [2:0]  verdict;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;        // [7:0] rx_byte

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;            // [7:0] payload_byte, [15:8] frame_type,
                                     // [31:16] frame_bytes, [34:32] verdict
  logic        out_tuser;            // [0] item_kind

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  crc_checked_frame_receiver_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic [7:0]    rx_bytes_pending[$];     // words waiting for the driver
  frame_result_t frame_results_due[$];    // results the parser model has produced
  frame_result_t result_head;

  int unsigned   bytes_queued = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  // Idle limits per side, changed between phases by the sequencer
  int unsigned   send_gap_max = 0;
  int unsigned   recv_gap_max = 0;
  int unsigned   send_wait;
  int unsigned   recv_wait;
  int unsigned   recv_draw;

  // Long receiver hold-off: sequencer bumps the request count, ready process serves it
  int unsigned   hold_requests = 0;
  int unsigned   holds_served;
  int unsigned   stall_left;

  // Shadow copy of the registers
  logic [7:0]    cfg_start_byte;
  logic [7:0]    cfg_end_byte;
  logic [15:0]   cfg_max_frame;

  // Parser model state
  ccfr_pkg::phase_t rx_phase;
  logic [15:0]   rx_count;
  logic [15:0]   rx_len;
  logic [31:0]   rx_crc;
  logic [31:0]   rx_crc_got;
  logic [7:0]    rx_type;

  // --------------------------------------------------------------------------
  // CRC-32, MSB first, one byte folded in bit by bit
  // --------------------------------------------------------------------------
  function automatic logic [31:0] crc32_msb_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    int          k;
    c = crc ^ {b, 24'h0};
    for (k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ ccfr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Parser model: advance on one accepted byte, queue the result it causes
  // --------------------------------------------------------------------------
  task automatic parse_rx_byte(input logic [7:0] b);
    frame_result_t r;
    logic [16:0]   total;
    bit            emit;
    r = '0;
    emit = 1'b0;
    case (rx_phase)
      ccfr_pkg::PH_TYPE: begin
        rx_type  = b;
        rx_phase = ccfr_pkg::PH_LEN_LO;
      end
      ccfr_pkg::PH_LEN_LO: begin
        rx_len   = {8'h00, b};
        rx_phase = ccfr_pkg::PH_LEN_HI;
      end
      ccfr_pkg::PH_LEN_HI: begin
        rx_len[15:8] = b;
        rx_count     = '0;
        rx_phase     = (rx_len == 16'd0) ? ccfr_pkg::PH_CRC : ccfr_pkg::PH_PAYLOAD;
      end
      ccfr_pkg::PH_PAYLOAD: begin
        rx_crc   = crc32_msb_byte(rx_crc, b);
        rx_count = rx_count + 16'd1;
        if (rx_count >= rx_len) begin
          rx_count = '0;
          rx_phase = ccfr_pkg::PH_CRC;
        end
        r.kind    = ccfr_pkg::KIND_PAYLOAD;
        r.payload = b;
        r.ftype   = rx_type;
        emit      = 1'b1;
      end
      ccfr_pkg::PH_CRC: begin
        // CRC arrives little-endian
        rx_crc_got = rx_crc_got | ({24'h0, b} << (8 * rx_count[1:0]));
        rx_count   = rx_count + 16'd1;
        if (rx_count >= 16'd4) begin
          rx_count = '0;
          rx_phase = ccfr_pkg::PH_END;
        end
      end
      ccfr_pkg::PH_END: begin
        // End byte beats CRC, CRC beats length; length compared at 17 bits
        total   = {1'b0, rx_len} + ccfr_pkg::FRAME_OVERHEAD;
        r.kind  = ccfr_pkg::KIND_VERDICT;
        r.ftype = rx_type;
        if (b != cfg_end_byte) begin
          r.verdict = ccfr_pkg::VERDICT_BAD_END;
        end else if (rx_crc != rx_crc_got) begin
          r.verdict = ccfr_pkg::VERDICT_BAD_CRC;
        end else if (total > {1'b0, cfg_max_frame}) begin
          r.verdict = ccfr_pkg::VERDICT_TOO_LONG;
        end else begin
          r.verdict = ccfr_pkg::VERDICT_OK;
          r.fbytes  = total[15:0];
        end
        emit     = 1'b1;
        rx_phase = ccfr_pkg::PH_IDLE;
        rx_count = '0;
      end
      default: begin
        rx_phase = ccfr_pkg::PH_IDLE;
        if (b == cfg_start_byte) begin
          rx_phase   = ccfr_pkg::PH_TYPE;
          rx_count   = '0;
          rx_len     = '0;
          rx_crc     = ccfr_pkg::CRC_INIT;
          rx_crc_got = '0;
          rx_type    = '0;
        end else begin
          // stray byte while idle
          r.kind    = ccfr_pkg::KIND_VERDICT;
          r.verdict = ccfr_pkg::VERDICT_BAD_START;
          emit      = 1'b1;
        end
      end
    endcase
    if (emit) frame_results_due.push_back(r);
  endtask

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued bytes, hold each one until taken, then idle for
  // the gap drawn when it was loaded
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_wait != 0) begin
        in_tvalid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (rx_bytes_pending.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_bytes_pending.pop_front();
        send_wait <= $urandom_range(0, send_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver ready: random gap after each taken word, plus a long hold-off
  // on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      recv_wait    <= 0;
      stall_left   <= 0;
      holds_served <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      stall_left   <= HOLD_OFF_CYCLES;
      out_tready   <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      recv_draw = $urandom_range(0, recv_gap_max);
      recv_wait  <= recv_draw;
      out_tready <= (recv_draw == 0);
    end else if (recv_wait != 0) begin
      recv_wait  <= recv_wait - 1;
      out_tready <= (recv_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check taken result words, feed taken input words to the model
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (frame_results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none, actual %0h/%0h",
                   $time, out_tuser, out_tdata);
        end else begin
          result_head = frame_results_due.pop_front();
          compare_field("item_kind",    {15'h0, result_head.kind},    {15'h0, out_tuser});
          compare_field("payload_byte", {8'h0, result_head.payload},  {8'h0, out_tdata[7:0]});
          compare_field("frame_type",   {8'h0, result_head.ftype},    {8'h0, out_tdata[15:8]});
          compare_field("frame_bytes",  result_head.fbytes,           out_tdata[31:16]);
          compare_field("verdict",      {13'h0, result_head.verdict}, {13'h0, out_tdata[34:32]});
          compare_field("tdata pad",    16'h0,                        {11'h0, out_tdata[39:35]});
        end
      end
      if (in_tvalid && in_tready) parse_rx_byte(in_tdata);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("crc_checked_frame_receiver_unit_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // APB access
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // register took the value at this edge; track it
    case (idx)
      ccfr_pkg::REG_START_BYTE: cfg_start_byte = data[7:0];
      ccfr_pkg::REG_END_BYTE:   cfg_end_byte   = data[7:0];
      ccfr_pkg::REG_MAX_FRAME:  cfg_max_frame  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic apb_read_check(input logic [1:0] idx);
    logic [31:0] want;
    logic [31:0] mask;
    case (idx)
      ccfr_pkg::REG_START_BYTE: begin
        want = {24'h0, cfg_start_byte};
        mask = 32'h0000_00FF;
      end
      ccfr_pkg::REG_END_BYTE: begin
        want = {24'h0, cfg_end_byte};
        mask = 32'h0000_00FF;
      end
      ccfr_pkg::REG_MAX_FRAME: begin
        want = {16'h0, cfg_max_frame};
        mask = 32'h0000_FFFF;
      end
      default: begin
        want = '0;
        mask = '0;
      end
    endcase
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if ((cfg_prdata & mask) !== want) begin
      mismatch_count++;
      $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
               $time, idx, want, cfg_prdata & mask);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_registers();
    apb_read_check(ccfr_pkg::REG_START_BYTE);
    apb_read_check(ccfr_pkg::REG_END_BYTE);
    apb_read_check(ccfr_pkg::REG_MAX_FRAME);
  endtask

  task automatic program_registers(input logic [7:0] sob, input logic [7:0] eob,
                                   input logic [15:0] max_bytes);
    apb_write(ccfr_pkg::REG_START_BYTE, {24'h0, sob});
    apb_write(ccfr_pkg::REG_END_BYTE,   {24'h0, eob});
    apb_write(ccfr_pkg::REG_MAX_FRAME,  {16'h0, max_bytes});
    check_registers();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  // Build a frame with the current start/end bytes. A nonzero keep cuts it
  // after that many bytes and fills the rest with noise; if the four header bytes
  // are kept, the parser still comes back to idle at the frame's end position.
  task automatic queue_frame(input logic [7:0] ftype, input int unsigned len,
                             input frame_fault_t fault, input int unsigned keep);
    logic [7:0]  frame_q[$];
    logic [31:0] crc;
    logic [7:0]  b;
    int unsigned i;
    crc = ccfr_pkg::CRC_INIT;
    frame_q.push_back(cfg_start_byte);
    frame_q.push_back(ftype);
    frame_q.push_back(8'(len));
    frame_q.push_back(8'(len >> 8));
    for (i = 0; i < len; i++) begin
      b   = $urandom_range(0, 255);
      crc = crc32_msb_byte(crc, b);
      frame_q.push_back(b);
    end
    if (fault == FAULT_CRC || fault == FAULT_BOTH) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    for (i = 0; i < 4; i++) frame_q.push_back(8'(crc >> (8 * i)));
    if (fault == FAULT_END || fault == FAULT_BOTH)
      frame_q.push_back(cfg_end_byte ^ 8'($urandom_range(1, 255)));
    else
      frame_q.push_back(cfg_end_byte);
    if (keep == 0 || keep > frame_q.size()) keep = frame_q.size();
    for (i = 0; i < frame_q.size(); i++) begin
      if (i < keep) queue_byte(frame_q[i]);
      else queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic [7:0] pick_marker_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_frame_limit();
    case ($urandom_range(0, 4))
      0:       return 16'd9;
      1:       return 16'd20;
      2:       return ccfr_pkg::MAX_FRAME_RST;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(9, 200));
    endcase
  endfunction

  // Mostly well-formed frames with random content, some faulty, some noise
  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned  first;
    int unsigned  pick;
    int unsigned  len;
    frame_fault_t fault;
    logic [7:0]   b;
    first = bytes_queued;
    while (bytes_queued - first < n_bytes) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(0, 24);
      if (pick < 72) begin
        case ($urandom_range(0, 9))
          0:       fault = FAULT_END;
          1:       fault = FAULT_CRC;
          2:       fault = FAULT_BOTH;
          default: fault = FAULT_NONE;
        endcase
        queue_frame(8'($urandom_range(0, 255)), len, fault, 0);
      end else if (pick < 87) begin
        // stray bytes; keep them off the start marker so framing stays in step
        repeat ($urandom_range(1, 4)) begin
          do b = 8'($urandom_range(0, 255)); while (b == cfg_start_byte);
          queue_byte(b);
        end
      end else begin
        // broken frame: header intact, tail replaced by noise
        queue_frame(8'($urandom_range(0, 255)), len, FAULT_NONE, $urandom_range(4, len + 8));
      end
    end
  endtask

  // Wait until every byte is taken and every result has come, then let the
  // pipeline drain before touching registers
  task automatic settle();
    @(negedge clk);
    while (rx_bytes_pending.size() != 0 || in_tvalid || frame_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    cfg_start_byte = ccfr_pkg::START_BYTE_RST;
    cfg_end_byte   = ccfr_pkg::END_BYTE_RST;
    cfg_max_frame  = ccfr_pkg::MAX_FRAME_RST;
    rx_phase       = ccfr_pkg::PH_IDLE;
    rx_count       = '0;
    rx_len         = '0;
    rx_crc         = ccfr_pkg::CRC_INIT;
    rx_crc_got     = '0;
    rx_type        = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    check_registers();

    // Reset settings: stray bytes, empty and one-byte payloads, each fault,
    // end byte winning over CRC, a length with the high byte set, a broken frame
    send_gap_max = 3;
    recv_gap_max = 3;
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_frame(8'h00, 0, FAULT_NONE, 0);
    queue_frame(8'hFF, 1, FAULT_NONE, 0);
    queue_frame(8'h5A, 3, FAULT_END, 0);
    queue_frame(8'hA5, 5, FAULT_CRC, 0);
    queue_frame(8'h3C, 2, FAULT_BOTH, 0);
    queue_frame(8'h81, 258, FAULT_NONE, 0);
    queue_frame(8'h42, 6, FAULT_NONE, 7);
    settle();

    // Smallest legal limit, markers at the extremes
    program_registers(8'h00, 8'hFF, 16'd9);
    queue_frame(8'h11, 0, FAULT_NONE, 0);       // exactly at the limit
    queue_frame(8'h22, 1, FAULT_NONE, 0);       // one byte over
    queue_byte(ccfr_pkg::START_BYTE_RST);       // old start marker is now a stray
    settle();

    // Swapped extremes; limit boundary; CRC checked before length
    send_gap_max = 17;
    recv_gap_max = 17;
    program_registers(8'hFF, 8'h00, 16'd20);
    queue_frame(8'h33, 11, FAULT_NONE, 0);
    queue_frame(8'h44, 12, FAULT_NONE, 0);
    queue_frame(8'h55, 12, FAULT_CRC, 0);
    settle();

    // Write to the unused index must leave every register alone
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    check_registers();

    // Limit below the frame overhead: even an empty frame is too long
    program_registers(8'hFF, 8'h00, 16'd0);
    queue_frame(8'h66, 0, FAULT_NONE, 0);
    settle();

    // Reset markers; payload at and just over a mid-size limit, back to back
    send_gap_max = 0;
    recv_gap_max = 0;
    program_registers(ccfr_pkg::START_BYTE_RST, ccfr_pkg::END_BYTE_RST, 16'd100);
    queue_frame(8'h77, 91, FAULT_NONE, 0);
    queue_frame(8'h88, 92, FAULT_NONE, 0);
    settle();

    // Random phases with fresh settings and idle profiles
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      program_registers(pick_marker_byte(), pick_marker_byte(), pick_frame_limit());
      case ($urandom_range(0, 3))
        0:       send_gap_max = 0;
        1:       send_gap_max = 5;
        default: send_gap_max = 17;
      endcase
      case ($urandom_range(0, 3))
        0:       recv_gap_max = 0;
        1:       recv_gap_max = 5;
        default: recv_gap_max = 17;
      endcase
      if (p == 2) begin
        // hold the output off while the sender keeps pushing, so input backs up
        send_gap_max = 0;
        hold_requests++;
      end
      queue_random_traffic(PHASE_BYTES);
      settle();
    end

    if (mismatch_count == 0 && frame_results_due.size() == 0) begin
      $display("crc_checked_frame_receiver_unit_tb: PASS");
    end else begin
      $display("crc_checked_frame_receiver_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ccfr_pkg.sv
hw/rtl/ccfr_crc_byte.sv
hw/rtl/crc_checked_frame_receiver_unit.sv
verif/crc_checked_frame_receiver_unit_tb.sv
